// ----- design/asc_pkg.sv -----
// Shared widths, codes, constants and helper functions for the ADC supply
// and temperature calibrator. No dependencies.
package asc_pkg;

    localparam int RAW_WINDOW_DEF  = 10;
    localparam int CALC_WINDOW_DEF = 60;

    localparam int SAMPLE_W  = 12;
    localparam int SUPPLY_W  = 54;
    localparam int TEMP_W    = 32;
    localparam int WORD_W    = 64;
    localparam int MUL_B_W   = 32;

    localparam logic [31:0] NV_PER_CNT = 32'd805664;
    localparam logic [31:0] SUPPLY_NV  = 32'd3300000000;

    // request kinds on the input tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSAMP = 2'd1;
    localparam logic [1:0] ST_DIV0   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VREF_CAL = 2'd0;
    localparam logic [1:0] CFG_TEMP_LOW = 2'd1;
    localparam logic [1:0] CFG_TEMP_HIGH = 2'd2;

    localparam logic [11:0] VREF_CAL_RST  = 12'd1489;
    localparam logic [11:0] TEMP_LOW_RST  = 12'd1775;
    localparam logic [11:0] TEMP_HIGH_RST = 12'd1348;

    typedef struct packed {
        logic              start;
        logic              sgn;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    function automatic logic [15:0] sat16(input logic [WORD_W-1:0] v);
        logic [15:0] r;
        r = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [WORD_W-1:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/asc_raw_win.sv -----
// One sliding window of 12-bit conversions with a running sum.
// Depends on asc_pkg.
module asc_raw_win #(
    parameter int  RAW_WINDOW = asc_pkg::RAW_WINDOW_DEF,
    localparam int SLOT_W = (RAW_WINDOW > 1) ? $clog2(RAW_WINDOW) : 1,
    localparam int RSUM_W = asc_pkg::SAMPLE_W + $clog2(RAW_WINDOW + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [SLOT_W-1:0]             i_slot,
    input  logic [asc_pkg::SAMPLE_W-1:0]  i_data,
    input  logic                          i_ok,
    output logic [RSUM_W-1:0]             o_sum
);
    import asc_pkg::*;

    logic [SAMPLE_W-1:0] r_win [RAW_WINDOW];
    logic [RSUM_W-1:0]   r_sum;
    logic [SAMPLE_W-1:0] w_new;

    // a failed conversion repeats the newest entry once full, else zero
    always_comb begin
        if (i_ok) begin
            w_new = i_data;
        end else if (i_full) begin
            w_new = r_win[RAW_WINDOW-1];
        end else begin
            w_new = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_full) begin
                for (int i = 0; i < RAW_WINDOW - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[RAW_WINDOW-1] <= w_new;
            end else begin
                for (int i = 0; i < RAW_WINDOW; i++) begin
                    if (i_slot == SLOT_W'(i)) begin
                        r_win[i] <= w_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_push) begin
            if (i_full) begin
                r_sum <= r_sum - RSUM_W'(r_win[0]) + RSUM_W'(w_new);
            end else begin
                r_sum <= r_sum + RSUM_W'(w_new);
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- design/asc_ser_div.sv -----
// Restoring divider, one quotient bit per cycle, with optional sign handling.
// Depends on asc_pkg.
module asc_ser_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asc_pkg::t_div_req           i_req,
    output logic [asc_pkg::WORD_W-1:0]  o_quot,
    output logic                        o_done
);
    import asc_pkg::*;

    logic              r_run;
    logic              r_fix;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [WORD_W:0]   r_rem;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_den;
    logic              r_neg;
    logic [WORD_W:0]   w_shift;
    logic [WORD_W+1:0] w_diff;
    logic              w_ge;
    logic              w_num_neg;
    logic              w_den_neg;

    assign w_shift   = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
    assign w_diff    = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge      = ~w_diff[WORD_W+1];
    assign w_num_neg = i_req.sgn & i_req.num[WORD_W-1];
    assign w_den_neg = i_req.sgn & i_req.den[WORD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run <= 1'b0;
                    r_fix <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= w_num_neg ? -i_req.num : i_req.num;
            r_den <= w_den_neg ? -i_req.den : i_req.den;
            r_neg <= w_num_neg ^ w_den_neg;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[WORD_W:0] : w_shift;
            r_q   <= {r_q[WORD_W-2:0], w_ge};
        end else if (r_fix) begin
            r_q <= r_neg ? -r_q : r_q;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ----- design/asc_ser_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, product kept to 64 bits.
// Depends on asc_pkg.
module asc_ser_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asc_pkg::t_mul_req           i_req,
    output logic [asc_pkg::WORD_W-1:0]  o_prod,
    output logic                        o_done
);
    import asc_pkg::*;

    logic               r_run;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [WORD_W-1:0]  r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [WORD_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_run) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[WORD_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ----- design/adc_supply_and_temp_calibrator_core.sv -----
// Top level of the ADC supply and temperature calibrator: sequencer, result
// windows and output register. Depends on asc_pkg, asc_raw_win, asc_ser_div,
// asc_ser_mul.
//
// Usage: the input stream carries a request kind on s_axis_tuser. A sample
// transfer pushes the three conversions into their sliding windows. An update
// transfer runs the calibration and gives exactly one result transfer on the
// output stream (status on m_axis_tuser). An update runs fourteen divisions
// on the single shared bit-serial divider and seven products on the
// bit-serial multiplier one after another. An update with no samples skips
// the arithmetic and goes straight to the result. The input is ready whenever
// the sequencer is idle, also while a result waits in the output register;
// a new result is held until the previous one has been taken.
// Configuration writes are taken at any time (ready is tied high) and are
// meant to happen only while the block is idle. Reset (synchronous, active
// low) empties all windows, restores the factory calibration words and drops
// any pending result. The result windows need no clearing pass: only written
// entries are ever read.
module adc_supply_and_temp_calibrator_core #(
    parameter int RAW_WINDOW  = asc_pkg::RAW_WINDOW_DEF,
    parameter int CALC_WINDOW = asc_pkg::CALC_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] raw_temp, [23:12] raw_vref, [35:24] raw_vbat,
    // [36] temp_ok, [37] vref_ok, [38] vbat_ok, [39] zero
    input  logic [39:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] vbat_mv, [47:16] temp_mf, [63:48] vcc_mv
    output logic [63:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import asc_pkg::*;

    localparam int SLOT_W  = (RAW_WINDOW > 1) ? $clog2(RAW_WINDOW) : 1;
    localparam int RCNT_W  = $clog2(RAW_WINDOW + 1);
    localparam int RSUM_W  = SAMPLE_W + $clog2(RAW_WINDOW + 1);
    localparam int CCNT_W  = $clog2(CALC_WINDOW + 1);
    localparam int PTR_W   = (CALC_WINDOW > 1) ? $clog2(CALC_WINDOW) : 1;
    localparam int SSUM_W  = SUPPLY_W + $clog2(CALC_WINDOW + 1);
    localparam int TSUM_W  = TEMP_W + $clog2(CALC_WINDOW + 1);

    typedef enum logic [25:0] {
        S_IDLE  = 26'h1 << 0,
        S_TAVG  = 26'h1 << 1,
        S_RAVG  = 26'h1 << 2,
        S_BAVG  = 26'h1 << 3,
        S_MA    = 26'h1 << 4,
        S_DA    = 26'h1 << 5,
        S_MBU   = 26'h1 << 6,
        S_DBU   = 26'h1 << 7,
        S_M30   = 26'h1 << 8,
        S_M110  = 26'h1 << 9,
        S_DU1   = 26'h1 << 10,
        S_DU2   = 26'h1 << 11,
        S_CHK   = 26'h1 << 12,
        S_MV    = 26'h1 << 13,
        S_DV    = 26'h1 << 14,
        S_PUSHS = 26'h1 << 15,
        S_DVA   = 26'h1 << 16,
        S_MT    = 26'h1 << 17,
        S_DMC   = 26'h1 << 18,
        S_DMF   = 26'h1 << 19,
        S_PUSHT = 26'h1 << 20,
        S_DTA   = 26'h1 << 21,
        S_MVB   = 26'h1 << 22,
        S_DVB   = 26'h1 << 23,
        S_DVC   = 26'h1 << 24,
        S_DONE  = 26'h1 << 25
    } t_state;

    t_state r_state;
    logic   r_go;

    // configuration
    logic [11:0] r_vref_cal;
    logic [11:0] r_temp_low;
    logic [11:0] r_temp_high;

    // raw windows
    logic [RCNT_W-1:0] r_raw_cnt;
    logic              w_raw_full;
    logic              w_push;
    logic              w_upd;
    logic [RSUM_W-1:0] w_tsum_raw;
    logic [RSUM_W-1:0] w_rsum_raw;
    logic [RSUM_W-1:0] w_bsum_raw;

    // result windows
    logic [SUPPLY_W-1:0]      r_sup_mem [CALC_WINDOW];
    logic signed [TEMP_W-1:0] r_tmp_mem [CALC_WINDOW];
    logic [SUPPLY_W-1:0]      r_sup_rd;
    logic signed [TEMP_W-1:0] r_tmp_rd;
    logic [PTR_W-1:0]         r_ptr;
    logic [CCNT_W-1:0]        r_calc_cnt;
    logic                     r_evict;
    logic [SSUM_W-1:0]        r_ssum;
    logic signed [TSUM_W-1:0] r_tsum;

    // working registers
    logic [SAMPLE_W-1:0]      r_tavg;
    logic [SAMPLE_W-1:0]      r_ravg;
    logic [SAMPLE_W-1:0]      r_bavg;
    logic [21:0]              r_auv;
    logic [21:0]              r_buv;
    logic [31:0]              r_nv30;
    logic signed [16:0]       r_uvpc;
    logic [SUPPLY_W-1:0]      r_vnv;
    logic [SUPPLY_W-1:0]      r_vavg;
    logic [WORD_W-1:0]        r_p;
    logic [WORD_W-1:0]        r_q;
    logic signed [TEMP_W-1:0] r_mf;

    // result fields and output register
    logic [1:0]  r_st;
    logic [15:0] r_vbat;
    logic [31:0] r_tmf;
    logic [15:0] r_vcc;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_st;

    // arithmetic units
    t_div_req          w_div_req;
    t_mul_req          w_mul_req;
    logic [WORD_W-1:0] w_div_q;
    logic              w_div_done;
    logic [WORD_W-1:0] w_mul_p;
    logic              w_mul_done;
    logic [WORD_W-1:0] w_npc;
    logic [WORD_W-1:0] w_mc;
    logic [WORD_W-1:0] w_mc9;
    logic [WORD_W-1:0] w_mf_full;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_push = s_axis_tvalid & s_axis_tready & (s_axis_tuser == REQ_SAMPLE);
    assign w_upd  = s_axis_tvalid & s_axis_tready & (s_axis_tuser == REQ_UPDATE);
    assign w_raw_full = (r_raw_cnt == RCNT_W'(RAW_WINDOW));

    // nanovolts per count, and the Celsius-to-Fahrenheit step
    assign w_npc     = 64'(r_vavg) >> 12;
    assign w_mc      = r_q + 64'd30000;
    assign w_mc9     = (w_mc << 3) + w_mc;
    assign w_mf_full = w_div_q + 64'd32000;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref_cal  <= VREF_CAL_RST;
            r_temp_low  <= TEMP_LOW_RST;
            r_temp_high <= TEMP_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VREF_CAL:  r_vref_cal  <= i_cfg_data;
                CFG_TEMP_LOW:  r_temp_low  <= i_cfg_data;
                CFG_TEMP_HIGH: r_temp_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Raw sample windows, one per channel, sharing one fill count
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_cnt <= '0;
        end else if (w_push && !w_raw_full) begin
            r_raw_cnt <= r_raw_cnt + RCNT_W'(1);
        end
    end

    asc_raw_win #(.RAW_WINDOW(RAW_WINDOW)) u_win_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_full  (w_raw_full),
        .i_slot  (r_raw_cnt[SLOT_W-1:0]),
        .i_data  (s_axis_tdata[11:0]),
        .i_ok    (s_axis_tdata[36]),
        .o_sum   (w_tsum_raw)
    );

    asc_raw_win #(.RAW_WINDOW(RAW_WINDOW)) u_win_vref (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_full  (w_raw_full),
        .i_slot  (r_raw_cnt[SLOT_W-1:0]),
        .i_data  (s_axis_tdata[23:12]),
        .i_ok    (s_axis_tdata[37]),
        .o_sum   (w_rsum_raw)
    );

    asc_raw_win #(.RAW_WINDOW(RAW_WINDOW)) u_win_vbat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_full  (w_raw_full),
        .i_slot  (r_raw_cnt[SLOT_W-1:0]),
        .i_data  (s_axis_tdata[35:24]),
        .i_ok    (s_axis_tdata[38]),
        .o_sum   (w_bsum_raw)
    );

    // ---------------------------------------------------------------------
    // Shared serial units
    // ---------------------------------------------------------------------
    asc_ser_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_div_q),
        .o_done  (w_div_done)
    );

    asc_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_prod  (w_mul_p),
        .o_done  (w_mul_done)
    );

    // Operand selection: each step fires its unit once, then waits for done.
    always_comb begin
        w_div_req = '{start: 1'b0, sgn: 1'b0, num: '0, den: 64'd1};
        w_mul_req = '{start: 1'b0, a: '0, b: '0};
        unique case (r_state)
            S_TAVG: w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: 64'(w_tsum_raw), den: 64'(r_raw_cnt)};
            S_RAVG: w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: 64'(w_rsum_raw), den: 64'(r_raw_cnt)};
            S_BAVG: w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: 64'(w_bsum_raw), den: 64'(r_raw_cnt)};
            S_MA:   w_mul_req = '{start: !r_go, a: 64'(r_vref_cal), b: NV_PER_CNT};
            S_DA, S_DBU:
                    w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: r_p + 64'd500, den: 64'd1000};
            S_MBU:  w_mul_req = '{start: !r_go, a: 64'(r_ravg), b: NV_PER_CNT};
            S_M30:  w_mul_req = '{start: !r_go, a: 64'(r_temp_low), b: NV_PER_CNT};
            S_M110: w_mul_req = '{start: !r_go, a: 64'(r_temp_high), b: NV_PER_CNT};
            S_DU1:  w_div_req = '{start: !r_go, sgn: 1'b1,
                                  num: r_p - 64'(r_nv30), den: 64'd80};
            S_DU2:  w_div_req = '{start: !r_go, sgn: 1'b1,
                                  num: r_q + 64'd500, den: 64'd1000};
            S_MV:   w_mul_req = '{start: !r_go, a: 64'(r_auv), b: SUPPLY_NV};
            S_DV:   w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: r_p, den: 64'(r_buv)};
            S_DVA:  w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: 64'(r_ssum), den: 64'(r_calc_cnt)};
            S_MT:   w_mul_req = '{start: !r_go, a: w_npc, b: 32'(r_tavg)};
            S_DMC:  w_div_req = '{start: !r_go, sgn: 1'b1,
                                  num: r_p - 64'(r_nv30), den: 64'(r_uvpc)};
            S_DMF:  w_div_req = '{start: !r_go, sgn: 1'b1,
                                  num: w_mc9, den: 64'd5};
            S_DTA:  w_div_req = '{start: !r_go, sgn: 1'b1,
                                  num: 64'(r_tsum), den: 64'(r_calc_cnt)};
            S_MVB:  w_mul_req = '{start: !r_go, a: w_npc, b: 32'(r_bavg)};
            S_DVB:  w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: r_p, den: 64'd1000000};
            S_DVC:  w_div_req = '{start: !r_go, sgn: 1'b0,
                                  num: 64'(r_vavg), den: 64'd1000000};
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Result windows: circular buffers with running sums
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSHS) begin
            r_sup_mem[r_ptr] <= r_vnv;
        end
        r_sup_rd <= r_sup_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSHT) begin
            r_tmp_mem[r_ptr] <= r_mf;
        end
        r_tmp_rd <= r_tmp_mem[r_ptr];
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_go       <= 1'b0;
            r_ptr      <= '0;
            r_calc_cnt <= '0;
            r_evict    <= 1'b0;
            r_ssum     <= '0;
            r_tsum     <= '0;
        end else begin
            if (w_div_req.start || w_mul_req.start) begin
                r_go <= 1'b1;
            end
            if (w_div_done || w_mul_done) begin
                r_go <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_upd) begin
                        r_vbat <= '0;
                        r_tmf  <= '0;
                        r_vcc  <= '0;
                        if (r_raw_cnt == '0) begin
                            r_st    <= ST_NOSAMP;
                            r_state <= S_DONE;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_TAVG;
                        end
                    end
                end
                S_TAVG: if (w_div_done) begin
                    r_tavg  <= w_div_q[SAMPLE_W-1:0];
                    r_state <= S_RAVG;
                end
                S_RAVG: if (w_div_done) begin
                    r_ravg  <= w_div_q[SAMPLE_W-1:0];
                    r_state <= S_BAVG;
                end
                S_BAVG: if (w_div_done) begin
                    r_bavg  <= w_div_q[SAMPLE_W-1:0];
                    r_state <= S_MA;
                end
                S_MA: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DA;
                end
                S_DA: if (w_div_done) begin
                    r_auv   <= w_div_q[21:0];
                    r_state <= S_MBU;
                end
                S_MBU: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DBU;
                end
                S_DBU: if (w_div_done) begin
                    r_buv   <= w_div_q[21:0];
                    r_state <= S_M30;
                end
                S_M30: if (w_mul_done) begin
                    r_nv30  <= w_mul_p[31:0];
                    r_state <= S_M110;
                end
                S_M110: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DU1;
                end
                S_DU1: if (w_div_done) begin
                    r_q     <= w_div_q;
                    r_state <= S_DU2;
                end
                S_DU2: if (w_div_done) begin
                    r_uvpc  <= w_div_q[16:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // a zero divisor ends the update without touching the windows
                    if (r_buv == '0 || r_uvpc == '0) begin
                        r_st    <= ST_DIV0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MV;
                    end
                end
                S_MV: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DV;
                end
                S_DV: if (w_div_done) begin
                    r_vnv   <= w_div_q[SUPPLY_W-1:0];
                    r_state <= S_PUSHS;
                end
                S_PUSHS: begin
                    // drop the oldest supply entry from the sum once full
                    if (r_calc_cnt == CCNT_W'(CALC_WINDOW)) begin
                        r_evict <= 1'b1;
                        r_ssum  <= r_ssum + SSUM_W'(r_vnv) - SSUM_W'(r_sup_rd);
                    end else begin
                        r_evict    <= 1'b0;
                        r_calc_cnt <= r_calc_cnt + CCNT_W'(1);
                        r_ssum     <= r_ssum + SSUM_W'(r_vnv);
                    end
                    r_state <= S_DVA;
                end
                S_DVA: if (w_div_done) begin
                    r_vavg  <= w_div_q[SUPPLY_W-1:0];
                    r_state <= S_MT;
                end
                S_MT: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DMC;
                end
                S_DMC: if (w_div_done) begin
                    r_q     <= w_div_q;
                    r_state <= S_DMF;
                end
                S_DMF: if (w_div_done) begin
                    r_mf    <= sat32(w_mf_full);
                    r_state <= S_PUSHT;
                end
                S_PUSHT: begin
                    if (r_evict) begin
                        r_tsum <= r_tsum + TSUM_W'(r_mf) - TSUM_W'(r_tmp_rd);
                    end else begin
                        r_tsum <= r_tsum + TSUM_W'(r_mf);
                    end
                    r_ptr   <= (r_ptr == PTR_W'(CALC_WINDOW - 1)) ? '0
                                                                   : r_ptr + PTR_W'(1);
                    r_state <= S_DTA;
                end
                S_DTA: if (w_div_done) begin
                    r_tmf   <= w_div_q[31:0];
                    r_state <= S_MVB;
                end
                S_MVB: if (w_mul_done) begin
                    r_p     <= w_mul_p;
                    r_state <= S_DVB;
                end
                S_DVB: if (w_div_done) begin
                    r_vbat  <= sat16(w_div_q);
                    r_state <= S_DVC;
                end
                S_DVC: if (w_div_done) begin
                    r_vcc   <= sat16(w_div_q);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {r_vcc, r_tmf, r_vbat};
            r_out_st   <= r_st;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_st;

endmodule
